@@ rtl/btlpm_pkg.sv @@
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared constants and controller/datapath interface types for the binary
// trie longest-prefix-match block.
// ----------------------------------------------------------------------------
package btlpm_pkg;

    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 6;
    localparam int ID_PORT_W = 16;
    localparam int WIDE_W    = 32;

    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic descend;
        logic set_id;
        logic link_new;
        logic fill_link;
        logic fill_id;
        logic fill_empty;
        logic set_full;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic lookup;
        logic at_end;
        logic child_zero;
        logic pool_full;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/binary_trie_longest_prefix_match.sv @@
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// IPv4 longest-prefix match over a one-bit-per-level binary trie.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one insert or lookup beat:
// mode, address, prefix length and route id. Output channel
// (o_out_valid / i_out_ready) returns one result beat per input beat:
// matched, match id and pool-full status.
// One item is in work at a time. The walk reads one trie node per cycle from
// the node RAM, up to 33 trie levels, between the accept and the hand-off
// states; the hand-off waits while the output register still holds a result.
// An insert that creates nodes spends one RAM write per new node in place of
// the read for that level.
// Reset empties the trie (root reads as empty until written) and sets the
// free-node counter to 1; no clearing pass is needed.
// A result waits in the output register while the receiver stalls; the next
// item is accepted meanwhile and its walk finishes, then it holds until the
// output register frees.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match #(
    parameter int NODE_COUNT = 1024,
    parameter int ID_WIDTH   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [btlpm_pkg::ADDR_W-1:0]      i_address,
    input  logic [btlpm_pkg::LEN_W-1:0]       i_prefix_len,
    input  logic [btlpm_pkg::ID_PORT_W-1:0]   i_entry_id,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_matched,
    output logic [btlpm_pkg::ID_PORT_W-1:0]   o_match_id,
    output logic                              o_status
);

    btlpm_pkg::t_dp_cmd    w_cmd;
    btlpm_pkg::t_dp_status w_stat;

    btlpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    btlpm_dp #(
        .NODE_COUNT (NODE_COUNT),
        .ID_WIDTH   (ID_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_prefix_len (i_prefix_len),
        .i_entry_id   (i_entry_id),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_matched    (o_matched),
        .o_match_id   (o_match_id),
        .o_status     (o_status)
    );

`ifndef NO_ASSERTIONS
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.descend, w_cmd.set_id, w_cmd.link_new,
                  w_cmd.fill_link, w_cmd.fill_id, w_cmd.fill_empty, w_cmd.emit}))
        else $error("more than one datapath command at once");

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.link_new || w_cmd.fill_link) |-> !w_stat.pool_full)
        else $error("node allocated from an exhausted pool");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("result beat lost after emit");

    a_full_unmatched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == btlpm_pkg::STATUS_FULL) |-> !o_matched)
        else $error("pool-full result flagged as matched");
`endif

endmodule

@@ rtl/btlpm_ram.sv @@
// ----------------------------------------------------------------------------
// btlpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module btlpm_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/btlpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// btlpm_ctrl
// Sequencer for the trie walk: one trie level per cycle, then allocation of
// fresh nodes for an insert, then hand-off of the result beat.
// ----------------------------------------------------------------------------
module btlpm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  btlpm_pkg::t_dp_status i_stat,
    output btlpm_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_ALLOC = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.lookup) begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.at_end || i_stat.child_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.descend = 1'b1;
                    end
                end else if (i_stat.at_end) begin
                    o_cmd.set_id = 1'b1;
                    n_state      = S_DONE;
                end else if (!i_stat.child_zero) begin
                    o_cmd.descend = 1'b1;
                end else if (i_stat.pool_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.link_new = 1'b1;
                    n_state        = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (i_stat.at_end) begin
                    o_cmd.fill_id = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.pool_full) begin
                    o_cmd.fill_empty = 1'b1;
                    o_cmd.set_full   = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.fill_link = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/btlpm_dp.sv @@
// ----------------------------------------------------------------------------
// btlpm_dp
// Trie datapath: node memory, walk registers, node allocator and result
// register.
// ----------------------------------------------------------------------------
module btlpm_dp #(
    parameter int NODE_COUNT = 1024,
    parameter int ID_WIDTH   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  btlpm_pkg::t_dp_cmd                    i_cmd,
    output btlpm_pkg::t_dp_status                 o_stat,
    input  logic                                  i_mode,
    input  logic [btlpm_pkg::ADDR_W-1:0]          i_address,
    input  logic [btlpm_pkg::LEN_W-1:0]           i_prefix_len,
    input  logic [btlpm_pkg::ID_PORT_W-1:0]       i_entry_id,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_matched,
    output logic [btlpm_pkg::ID_PORT_W-1:0]       o_match_id,
    output logic                                  o_status
);

    localparam int LINK_W    = $clog2(NODE_COUNT);
    localparam int NF_W      = $clog2(NODE_COUNT + 1);
    localparam int NODE_W    = 2 * LINK_W + 1 + ID_WIDTH;
    localparam int VALID_BIT = ID_WIDTH;
    localparam int ZERO_LSB  = ID_WIDTH + 1;
    localparam int ONE_LSB   = ID_WIDTH + 1 + LINK_W;

    logic                              r_mode;
    logic [btlpm_pkg::ADDR_W-1:0]      r_addr;
    logic [btlpm_pkg::LEN_W-1:0]       r_len;
    logic [ID_WIDTH-1:0]               r_id;
    logic [btlpm_pkg::LEN_W-1:0]       r_depth;
    logic [LINK_W-1:0]                 r_node;
    logic [NF_W-1:0]                   r_nf;
    logic                              r_root_valid;
    logic                              r_hit;
    logic [ID_WIDTH-1:0]               r_best;
    logic                              r_full;
    logic                              r_out_valid;
    logic                              r_out_matched;
    logic [btlpm_pkg::ID_PORT_W-1:0]   r_out_id;
    logic                              r_out_status;

    logic [NODE_W-1:0]                 w_rdata;
    logic [NODE_W-1:0]                 w_node;
    logic [NODE_W-1:0]                 w_wdata;
    logic                              w_we;
    logic [LINK_W-1:0]                 w_raddr;
    logic                              w_bit;
    logic [LINK_W-1:0]                 w_child;
    logic [LINK_W-1:0]                 w_new_link;
    logic                              w_advance;
    logic [btlpm_pkg::LEN_W-1:0]       w_len_sat;
    logic [btlpm_pkg::WIDE_W-1:0]      w_id_in;
    logic [btlpm_pkg::WIDE_W-1:0]      w_best_wide;

    btlpm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_node),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // root reads as empty until first written
    assign w_node     = (r_node == '0 && !r_root_valid) ? '0 : w_rdata;
    assign w_bit      = r_addr[btlpm_pkg::ADDR_W-1];
    assign w_child    = w_bit ? w_node[ONE_LSB +: LINK_W] : w_node[ZERO_LSB +: LINK_W];
    assign w_new_link = r_nf[LINK_W-1:0];
    assign w_raddr    = i_cmd.descend ? w_child : '0;
    assign w_advance  = i_cmd.descend || i_cmd.link_new || i_cmd.fill_link;
    assign w_len_sat  = (i_prefix_len > btlpm_pkg::MAX_LEN) ? btlpm_pkg::MAX_LEN
                                                             : i_prefix_len;
    assign w_id_in     = btlpm_pkg::WIDE_W'(i_entry_id);
    assign w_best_wide = btlpm_pkg::WIDE_W'(r_best);

    assign w_we = i_cmd.set_id || i_cmd.link_new || i_cmd.fill_link
               || i_cmd.fill_id || i_cmd.fill_empty;

    always_comb begin
        w_wdata = (i_cmd.set_id || i_cmd.link_new) ? w_node : '0;
        if (i_cmd.link_new || i_cmd.fill_link) begin
            if (w_bit) begin
                w_wdata[ONE_LSB +: LINK_W] = w_new_link;
            end else begin
                w_wdata[ZERO_LSB +: LINK_W] = w_new_link;
            end
        end
        if (i_cmd.set_id || i_cmd.fill_id) begin
            w_wdata[VALID_BIT]      = 1'b1;
            w_wdata[0 +: ID_WIDTH]  = r_id;
        end
    end

    assign o_stat.lookup     = (r_mode == btlpm_pkg::MODE_LOOKUP);
    assign o_stat.at_end     = (r_mode == btlpm_pkg::MODE_LOOKUP)
                             ? (r_depth == btlpm_pkg::MAX_LEN) : (r_depth == r_len);
    assign o_stat.child_zero = (w_child == '0);
    assign o_stat.pool_full  = (r_nf >= NF_W'(NODE_COUNT));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_valid <= 1'b0;
            r_nf         <= NF_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (w_we && r_node == '0) begin
                r_root_valid <= 1'b1;
            end
            if (i_cmd.link_new || i_cmd.fill_link) begin
                r_nf <= r_nf + NF_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_len   <= w_len_sat;
            r_id    <= w_id_in[ID_WIDTH-1:0];
            r_depth <= '0;
            r_node  <= '0;
            r_hit   <= 1'b0;
            r_best  <= '0;
            r_full  <= 1'b0;
        end else begin
            if (w_advance) begin
                r_depth <= r_depth + btlpm_pkg::LEN_W'(1);
                r_addr  <= {r_addr[btlpm_pkg::ADDR_W-2:0], 1'b0};
                r_node  <= i_cmd.descend ? w_child : w_new_link;
            end
            if (i_cmd.scan && w_node[VALID_BIT]) begin
                r_hit  <= 1'b1;
                r_best <= w_node[0 +: ID_WIDTH];
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_out_matched <= r_hit;
            r_out_id      <= w_best_wide[btlpm_pkg::ID_PORT_W-1:0];
            r_out_status  <= r_full ? btlpm_pkg::STATUS_FULL : btlpm_pkg::STATUS_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out_matched;
    assign o_match_id  = r_out_id;
    assign o_status    = r_out_status;

endmodule
